>>> hdl/wildcard_group_score_count_defines.svh
// Assertion macros for the wildcard group score count block
`ifndef WILDCARD_GROUP_SCORE_COUNT_DEFINES_SVH
`define WILDCARD_GROUP_SCORE_COUNT_DEFINES_SVH
`ifndef SYNTH
`define WGSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wgsc assertion failed");
`define WGSC_ASSERT_NR(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wgsc assertion failed");
`else
`define WGSC_ASSERT(label, prop)
`define WGSC_ASSERT_NR(label, prop)
`endif
`endif

>>> hdl/wgsc_pkg.sv
// Shared types and constants of the wildcard group score count block
package wgsc_pkg;

  localparam int GROUPS   = 24;
  localparam int GRP_BITS = 5;
  localparam int SCORE_W  = 10;
  localparam int MATCH_W  = 16;
  localparam int Q_DEPTH  = 2;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_QUERY  = 1'b1;
  localparam logic [1:0] CAT_ANY_FIRST = 2'd3;

  typedef struct packed {
    logic                query;
    logic [GRP_BITS-1:0] grp;
    logic [GROUPS-1:0]   mask;
    logic [SCORE_W-1:0]  score;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } front_q_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_RD,
    S_INS_UPD,
    S_TREE_RD,
    S_TREE_WR,
    S_QRY_GRP,
    S_QRY_RD,
    S_QRY_ACC,
    S_QRY_DONE
  } back_state_t;

endpackage

>>> hdl/wgsc_ram.sv
// Generic single write port, single read port RAM with registered read
module wgsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/wgsc_front.sv
// Front end: accept requests, classify them and queue commands for the back end
module wgsc_front import wgsc_pkg::*; #(
  parameter int SCORE_MAX = 1023
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_op,
  input  logic [1:0]         in_cat_first,
  input  logic [1:0]         in_cat_second,
  input  logic [1:0]         in_cat_third,
  input  logic [1:0]         in_cat_fourth,
  input  logic [SCORE_W-1:0] in_score,
  input  back_ctl_t          ctl,
  output front_q_t           q
);

  cmd_t       q_r [Q_DEPTH];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  cmd_t               cmd;
  logic               keep;
  logic               accept;
  logic [SCORE_W-1:0] score_c;
  logic               thr_over;

  always_comb begin
    logic [1:0] a;
    logic       b, c, d;
    thr_over = 32'(in_score) > SCORE_MAX;
    score_c  = thr_over ? SCORE_W'(SCORE_MAX) : in_score;
    cmd.query = (in_op == OP_QUERY);
    cmd.grp   = {in_cat_first, in_cat_second[0], in_cat_third[0], in_cat_fourth[0]};
    cmd.score = score_c;
    for (int g = 0; g < GROUPS; g++) begin
      a = 2'(g >> 3);
      b = 1'(g >> 2);
      c = 1'(g >> 1);
      d = 1'(g);
      cmd.mask[g] = !thr_over
        && (in_cat_first == CAT_ANY_FIRST || in_cat_first == a)
        && (in_cat_second[1] || in_cat_second[0] == b)
        && (in_cat_third[1] || in_cat_third[0] == c)
        && (in_cat_fourth[1] || in_cat_fourth[0] == d);
    end
    keep = cmd.query || (in_cat_first != CAT_ANY_FIRST && !in_cat_second[1]
                         && !in_cat_third[1] && !in_cat_fourth[1]);
  end

  assign full   = (cnt_r == 2'(Q_DEPTH)) || ctl.clearing;
  assign accept = push && !full && keep;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (ctl.pop) begin
      rp_nxt = rp_r + 1'b1;
    end
    if (accept && !ctl.pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!accept && ctl.pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wp_r] <= cmd;
    end
  end

  assign q.valid = (cnt_r != 2'd0);
  assign q.cmd   = q_r[rp_r];

endmodule

>>> hdl/wgsc_back.sv
// Back end: bucket counters, per-group score trees, query sweep and result register
module wgsc_back import wgsc_pkg::*; #(
  parameter int SCORE_MAX  = 1023,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  front_q_t           q,
  output back_ctl_t          ctl,
  output logic               empty,
  input  logic               pop,
  output logic [MATCH_W-1:0] out_match_count
);

  localparam int SB    = $clog2(SCORE_MAX + 1);
  localparam int IW    = SB + 2;
  localparam int TW    = COUNT_BITS + SB;
  localparam int AW    = GRP_BITS + SB;
  localparam int DEPTH = GROUPS << SB;
  localparam int XW    = (IW > SCORE_W) ? IW : SCORE_W;
  localparam logic [XW-1:0]         N_X       = XW'(SCORE_MAX + 1);
  localparam logic [IW-1:0]         N_I       = IW'(SCORE_MAX + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [AW-1:0]         CLR_LAST  = AW'(DEPTH - 1);
  localparam logic [GRP_BITS-1:0]   GRP_END   = GRP_BITS'(GROUPS);

  back_state_t state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [GRP_BITS-1:0] grp_r, grp_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] acc_r, acc_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MATCH_W-1:0]  out_count_r, out_count_nxt;

  logic                  b_we, t_we;
  logic [AW-1:0]         b_waddr, b_raddr, t_waddr, t_raddr;
  logic [COUNT_BITS-1:0] b_wdata, b_rdata;
  logic [TW-1:0]         t_wdata, t_rdata;

  logic [XW-1:0]       score_x;
  logic [IW-1:0]       idx0, idx_m1, lowbit, idx_up, idx_dn;
  logic [GRP_BITS-1:0] t_grp;
  logic [TW:0]         sum_w;
  logic [COUNT_BITS-1:0] acc_sat;

  wgsc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_bucket (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  wgsc_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tree (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign score_x = XW'(cmd_r.score);
  assign idx0    = IW'(N_X - score_x);
  assign idx_m1  = idx_r - IW'(1);
  assign lowbit  = idx_r & (~idx_r + IW'(1));
  assign idx_up  = idx_r + lowbit;
  assign idx_dn  = idx_r & idx_m1;
  assign t_grp   = cmd_r.query ? grp_r : cmd_r.grp;
  assign b_raddr = {cmd_r.grp, score_x[SB-1:0]};
  assign t_raddr = {t_grp, idx_m1[SB-1:0]};
  assign sum_w   = (TW+1)'(acc_r) + (TW+1)'(t_rdata);
  assign acc_sat = (sum_w > (TW+1)'(COUNT_MAX)) ? COUNT_MAX : sum_w[COUNT_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    grp_nxt       = grp_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !pop;
    out_count_nxt = out_count_r;
    b_we          = 1'b0;
    b_waddr       = b_raddr;
    b_wdata       = b_rdata + COUNT_BITS'(1);
    t_we          = 1'b0;
    t_waddr       = t_raddr;
    t_wdata       = t_rdata + TW'(1);
    ctl.pop       = 1'b0;
    ctl.clearing  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.clearing = 1'b1;
        b_we    = 1'b1;
        t_we    = 1'b1;
        b_waddr = clr_r;
        t_waddr = clr_r;
        b_wdata = '0;
        t_wdata = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q.valid) begin
          ctl.pop   = 1'b1;
          cmd_nxt   = q.cmd;
          grp_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = q.cmd.query ? S_QRY_GRP : S_INS_RD;
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_UPD;
      end
      S_INS_UPD: begin
        if (b_rdata == COUNT_MAX) begin
          state_nxt = S_IDLE;
        end else begin
          b_we      = 1'b1;
          idx_nxt   = idx0;
          state_nxt = S_TREE_RD;
        end
      end
      S_TREE_RD: begin
        state_nxt = S_TREE_WR;
      end
      S_TREE_WR: begin
        t_we    = 1'b1;
        idx_nxt = idx_up;
        state_nxt = (idx_up > N_I) ? S_IDLE : S_TREE_RD;
      end
      S_QRY_GRP: begin
        if (grp_r == GRP_END) begin
          state_nxt = S_QRY_DONE;
        end else if (cmd_r.mask[grp_r]) begin
          idx_nxt   = idx0;
          state_nxt = S_QRY_RD;
        end else begin
          grp_nxt = grp_r + GRP_BITS'(1);
        end
      end
      S_QRY_RD: begin
        state_nxt = S_QRY_ACC;
      end
      S_QRY_ACC: begin
        acc_nxt = acc_sat;
        idx_nxt = idx_dn;
        if (idx_dn == '0) begin
          grp_nxt   = grp_r + GRP_BITS'(1);
          state_nxt = S_QRY_GRP;
        end else begin
          state_nxt = S_QRY_RD;
        end
      end
      S_QRY_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = MATCH_W'(acc_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    grp_r       <= grp_nxt;
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
  end

  assign empty           = !out_valid_r;
  assign out_match_count = out_count_r;

endmodule

>>> hdl/wildcard_group_score_count.sv
// Top level of the wildcard group score count block
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+-------------------------
//   input    | in_op in_cat_first..in_cat_fourth in_score    | push, full
//   result   | out_match_count                               | pop, empty
//
// Insert: dispatch, bucket read and update, a read and a write per tree node (at most SB+1 nodes).
// Query: dispatch, 24 group slots, end check and result, plus a read and an accumulate step
//   per tree node read in each matching group, through the single tree memory read port.
// Reset clears all 24 * 2^SB entries (SB = bits of SCORE_MAX, 24576 at defaults); full stays high.
// A two-entry command queue lets requests arrive while the back end works; a finished
//   result waits in the output register until popped.
`include "wildcard_group_score_count_defines.svh"
module wildcard_group_score_count import wgsc_pkg::*; #(
  parameter int SCORE_MAX  = 1023,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_op,
  input  logic [1:0]         in_cat_first,
  input  logic [1:0]         in_cat_second,
  input  logic [1:0]         in_cat_third,
  input  logic [1:0]         in_cat_fourth,
  input  logic [SCORE_W-1:0] in_score,
  output logic               empty,
  input  logic               pop,
  output logic [MATCH_W-1:0] out_match_count
);

  front_q_t  q;
  back_ctl_t ctl;

  wgsc_front #(.SCORE_MAX(SCORE_MAX)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_op         (in_op),
    .in_cat_first  (in_cat_first),
    .in_cat_second (in_cat_second),
    .in_cat_third  (in_cat_third),
    .in_cat_fourth (in_cat_fourth),
    .in_score      (in_score),
    .ctl           (ctl),
    .q             (q)
  );

  wgsc_back #(.SCORE_MAX(SCORE_MAX), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q               (q),
    .ctl             (ctl),
    .empty           (empty),
    .pop             (pop),
    .out_match_count (out_match_count)
  );

  `WGSC_ASSERT(a_clear_blocks_input, ctl.clearing |-> full)
  `WGSC_ASSERT(a_no_dispatch_in_clear, ctl.clearing |-> !ctl.pop)
  `WGSC_ASSERT(a_dispatch_needs_cmd, ctl.pop |-> q.valid)
  `WGSC_ASSERT_NR(a_reset_starts_clear, !rst_n |=> ctl.clearing && empty)

endmodule

>>> verif/testbench.sv
// Testbench for the wildcard group score count block: directed and random requests, scoreboard
`timescale 1ns / 100ps

module testbench;
  import wgsc_pkg::*;

  localparam int          SCORE_LIMIT = 1023;
  localparam int          SCORES      = SCORE_LIMIT + 1;
  localparam int          COUNT_LIMIT = 65535;
  localparam logic [1:0]  CAT_ANY     = 2'd2;
  localparam int          RANDOM_ITEMS = 900;
  localparam int          QUIET_ITEMS  = 100;
  localparam int          TAIL_CYCLES  = 700;
  localparam int          CYCLE_LIMIT  = 3000000;

  class count_scoreboard;
    bit [MATCH_W-1:0] bucket_counts [GROUPS*SCORES];
    bit [MATCH_W-1:0] pending_counts [$];
    int               errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void note_request(input logic op, input logic [1:0] c0, input logic [1:0] c1,
                               input logic [1:0] c2, input logic [1:0] c3,
                               input logic [SCORE_W-1:0] sc);
      int              idx;
      int              a;
      int              b;
      int              c;
      int              d;
      longint unsigned total;
      if (op == OP_INSERT) begin
        if (c0 > 2 || c1 > 1 || c2 > 1 || c3 > 1) return;
        idx = ((((c0 * 2 + c1) * 2 + c2) * 2 + c3) * SCORES) + sc;
        if (bucket_counts[idx] < COUNT_LIMIT) bucket_counts[idx]++;
        return;
      end
      total = 0;
      for (int g = 0; g < GROUPS; g++) begin
        a = g / 8;
        b = (g / 4) % 2;
        c = (g / 2) % 2;
        d = g % 2;
        if ((c0 == CAT_ANY_FIRST || c0 == a) && (c1 > 1 || c1 == b) &&
            (c2 > 1 || c2 == c) && (c3 > 1 || c3 == d)) begin
          for (int s = sc; s < SCORES; s++) begin
            total += bucket_counts[g * SCORES + s];
            if (total > COUNT_LIMIT) total = COUNT_LIMIT;
          end
        end
      end
      pending_counts = {pending_counts, total[MATCH_W-1:0]};
    endfunction

    task check_result(input logic [MATCH_W-1:0] got);
      bit [MATCH_W-1:0] want;
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result match_count=%0d", got));
        return;
      end
      want = pending_counts.pop_front();
      if (got !== want)
        report_mismatch($sformatf("match_count got %0d, want %0d", got, want));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               in_op = OP_INSERT;
  logic [1:0]         in_cat_first = 2'd0;
  logic [1:0]         in_cat_second = 2'd0;
  logic [1:0]         in_cat_third = 2'd0;
  logic [1:0]         in_cat_fourth = 2'd0;
  logic [SCORE_W-1:0] in_score = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [MATCH_W-1:0] out_match_count;

  count_scoreboard sb = new();
  bit              quiet_tail = 1'b0;
  int              cycle_count = 0;

  wildcard_group_score_count DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_op           (in_op),
    .in_cat_first    (in_cat_first),
    .in_cat_second   (in_cat_second),
    .in_cat_third    (in_cat_third),
    .in_cat_fourth   (in_cat_fourth),
    .in_score        (in_score),
    .empty           (empty),
    .pop             (pop),
    .out_match_count (out_match_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && push && !full)
      sb.note_request(in_op, in_cat_first, in_cat_second, in_cat_third, in_cat_fourth,
                      in_score);
    if (rst_n && pop && !empty)
      sb.check_result(out_match_count);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 6) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic issue(input logic op, input logic [1:0] c0, input logic [1:0] c1,
                       input logic [1:0] c2, input logic [1:0] c3,
                       input logic [SCORE_W-1:0] sc);
    int gap;
    in_op         <= op;
    in_cat_first  <= c0;
    in_cat_second <= c1;
    in_cat_third  <= c2;
    in_cat_fourth <= c3;
    in_score      <= sc;
    push          <= 1'b1;
    do @(posedge clk); while (full);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 3))
      0:       return SCORE_W'($urandom_range(0, 15));
      1:       return SCORE_W'($urandom_range(SCORE_LIMIT - 15, SCORE_LIMIT));
      default: return SCORE_W'($urandom_range(0, SCORE_LIMIT));
    endcase
  endfunction

  function automatic logic [1:0] pick_query_code(input int codes);
    if ($urandom_range(0, 1) == 0) return 2'($urandom_range(0, codes - 1));
    if (codes == 3) return CAT_ANY_FIRST;
    return 2'($urandom_range(CAT_ANY, 3));
  endfunction

  initial begin : stimulus
    int                 counted;
    logic               op;
    logic [1:0]         c0;
    logic [1:0]         c1;
    logic [1:0]         c2;
    logic [1:0]         c3;
    logic [SCORE_W-1:0] sc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    issue(OP_QUERY,  CAT_ANY_FIRST, CAT_ANY, CAT_ANY, CAT_ANY, 10'd0);
    issue(OP_INSERT, 2'd0, 2'd0, 2'd0, 2'd0, 10'd0);
    issue(OP_INSERT, 2'd2, 2'd1, 2'd1, 2'd1, 10'd1023);
    issue(OP_INSERT, 2'd1, 2'd0, 2'd1, 2'd0, 10'd512);
    issue(OP_INSERT, 2'd2, 2'd1, 2'd1, 2'd1, 10'd1023);
    issue(OP_INSERT, 2'd0, 2'd0, 2'd0, 2'd0, 10'd0);
    issue(OP_INSERT, 2'd1, 2'd1, 2'd0, 2'd1, 10'd341);
    issue(OP_INSERT, CAT_ANY_FIRST, 2'd0, 2'd0, 2'd0, 10'd100);
    issue(OP_INSERT, 2'd0, CAT_ANY, 2'd0, 2'd0, 10'd100);
    issue(OP_INSERT, 2'd0, 2'd0, 2'd3, 2'd0, 10'd100);
    issue(OP_INSERT, 2'd0, 2'd0, 2'd0, CAT_ANY, 10'd100);
    issue(OP_QUERY,  CAT_ANY_FIRST, CAT_ANY, CAT_ANY, CAT_ANY, 10'd0);
    issue(OP_QUERY,  CAT_ANY_FIRST, CAT_ANY, CAT_ANY, CAT_ANY, 10'd1023);
    issue(OP_QUERY,  2'd0, 2'd0, 2'd0, 2'd0, 10'd0);
    issue(OP_QUERY,  2'd2, 2'd1, 2'd1, 2'd1, 10'd1023);
    issue(OP_QUERY,  CAT_ANY_FIRST, 2'd3, 2'd3, 2'd3, 10'd1);
    issue(OP_QUERY,  2'd1, CAT_ANY, CAT_ANY, CAT_ANY, 10'd512);
    issue(OP_QUERY,  2'd1, CAT_ANY, CAT_ANY, CAT_ANY, 10'd513);
    issue(OP_QUERY,  CAT_ANY_FIRST, CAT_ANY, 2'd1, 2'd0, 10'd0);
    issue(OP_QUERY,  2'd1, 2'd1, 2'd3, 2'd1, 10'd341);
    issue(OP_QUERY,  2'd2, 2'd0, 2'd0, 2'd0, 10'd0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet_tail = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
      if ($urandom_range(0, 9) < 6) begin
        op = OP_INSERT;
        sc = pick_score();
        if ($urandom_range(0, 9) == 0) begin
          c0 = 2'($urandom());
          c1 = 2'($urandom());
          c2 = 2'($urandom());
          c3 = 2'($urandom());
        end else begin
          c0 = 2'($urandom_range(0, 2));
          c1 = 2'($urandom_range(0, 1));
          c2 = 2'($urandom_range(0, 1));
          c3 = 2'($urandom_range(0, 1));
        end
        if (c0 <= 2 && c1 <= 1 && c2 <= 1 && c3 <= 1) counted++;
      end else begin
        op = OP_QUERY;
        sc = ($urandom_range(0, 3) == 0) ? 10'd0 : pick_score();
        c0 = pick_query_code(3);
        c1 = pick_query_code(2);
        c2 = pick_query_code(2);
        c3 = pick_query_code(2);
        counted++;
      end
      issue(op, c0, c1, c2, c3, sc);
    end

    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_counts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
